>>> rtl/lirs_pkg.sv
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared constants and controller/datapath types for the stereo linear
// interpolation resampler.
// ----------------------------------------------------------------------------
package lirs_pkg;

    localparam int unsigned SAMPLE_W        = 16;
    localparam int unsigned RATE_W          = 16;
    localparam int unsigned CFG_IDX_W       = 1;
    localparam int unsigned PHASE_FRAC_DEF  = 16;
    localparam int unsigned MAX_OUT         = 6;
    localparam int unsigned CNT_W           = 3;

    localparam logic [RATE_W-1:0] OUT_RATE  = 16'd44100;
    localparam logic [RATE_W-1:0] PASS_RATE = 16'd44100;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_INPUT = 1'd1;

    typedef struct packed {
        logic load;
        logic pass;
        logic mul;
        logic emit;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic pass_mode;
        logic phase_low;
        logic out_last;
    } t_dp_sts;

endpackage

>>> rtl/lirs_in_if.sv
// ----------------------------------------------------------------------------
// lirs_in_if
// Input frame channel: valid/ready handshake with a stereo PCM payload.
// ----------------------------------------------------------------------------
interface lirs_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lirs_pkg::SAMPLE_W-1:0]  left_sample;
    logic signed [lirs_pkg::SAMPLE_W-1:0]  right_sample;
    logic                                  chunk_end;

    modport source (output valid, left_sample, right_sample, chunk_end, input ready);
    modport sink   (input valid, left_sample, right_sample, chunk_end, output ready);
endinterface

>>> rtl/lirs_out_if.sv
// ----------------------------------------------------------------------------
// lirs_out_if
// Output frame channel: valid/ready handshake with a resampled stereo payload.
// ----------------------------------------------------------------------------
interface lirs_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lirs_pkg::SAMPLE_W-1:0]  out_left;
    logic signed [lirs_pkg::SAMPLE_W-1:0]  out_right;
    logic                                  run_last;

    modport source (output valid, out_left, out_right, run_last, input ready);
    modport sink   (input valid, out_left, out_right, run_last, output ready);
endinterface

>>> rtl/linear_interp_resampler_stereo.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler_stereo
// Converts stereo 16-bit PCM frames at a programmable source rate to 44.1 kHz
// by linear interpolation with a 2.16 phase accumulator.
//
// i_src carries one input frame per transaction (left, right, chunk_end); o_res
// carries the resampled frames, run_last set on the last frame that an input
// produced. An input yields zero to six output frames; at a source rate of
// 44100 each frame passes through unchanged with run_last set. Writing
// source_rate recomputes the phase step by a reciprocal multiplication, holding
// i_src off while it is pending; stereo_input takes effect on the next frame.
// One input frame at a time: after the input transaction the controller passes
// through its check and emit states before the first interpolated output is
// offered, and each further output passes through the multiplier stage and the
// single output register again. Reset selects passthrough, stereo, phase and
// history zero. While the receiver stalls, the output frame holds and no new
// input is accepted.
// ----------------------------------------------------------------------------
module linear_interp_resampler_stereo #(
    parameter int unsigned PHASE_FRAC_BITS = lirs_pkg::PHASE_FRAC_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [lirs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lirs_pkg::RATE_W-1:0]        i_cfg_wdata,
    lirs_in_if.sink                            i_src,
    lirs_out_if.source                         o_res
);

    lirs_pkg::t_dp_cmd w_cmd;
    lirs_pkg::t_dp_sts w_sts;

    lirs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_src.valid),
        .o_in_ready  (i_src.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lirs_dp #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_left      (i_src.left_sample),
        .i_right     (i_src.right_sample),
        .o_left      (o_res.out_left),
        .o_right     (o_res.out_right),
        .o_last      (o_res.run_last)
    );

endmodule

>>> rtl/lirs_dp.sv
// ----------------------------------------------------------------------------
// lirs_dp
// Datapath: configuration registers, phase-step reciprocal multiplier, phase
// accumulator, per-channel interpolation multipliers and the output frame
// register.
// ----------------------------------------------------------------------------
module lirs_dp #(
    parameter int unsigned PHASE_FRAC_BITS = lirs_pkg::PHASE_FRAC_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lirs_pkg::t_dp_cmd                    i_cmd,
    output lirs_pkg::t_dp_sts                    o_sts,
    input  logic                                 i_cfg_wr_en,
    input  logic [lirs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lirs_pkg::RATE_W-1:0]          i_cfg_wdata,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] i_left,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] i_right,
    output logic signed [lirs_pkg::SAMPLE_W-1:0] o_left,
    output logic signed [lirs_pkg::SAMPLE_W-1:0] o_right,
    output logic                                 o_last
);

    localparam int unsigned SW        = lirs_pkg::SAMPLE_W;
    localparam int unsigned RW        = lirs_pkg::RATE_W;
    localparam int unsigned STEP_W    = PHASE_FRAC_BITS + 1;
    localparam int unsigned PHASE_W   = PHASE_FRAC_BITS + 2;
    localparam int unsigned RECIP_SH  = 32;
    localparam int unsigned RECIP_W   = PHASE_FRAC_BITS + 17;
    localparam int unsigned RPROD_W   = RW + RECIP_W;
    localparam int unsigned PROD_W    = SW + 2 + PHASE_FRAC_BITS;
    localparam logic [STEP_W-1:0]  STEP_RST = {1'b1, {PHASE_FRAC_BITS{1'b0}}};
    localparam logic [PHASE_W-1:0] ONE      = {2'b01, {PHASE_FRAC_BITS{1'b0}}};
    // ceil(2^(frac + 32) / output rate): exact floor quotient for any 16-bit rate
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(
        ((64'd1 << (PHASE_FRAC_BITS + RECIP_SH)) + 64'(lirs_pkg::OUT_RATE) - 64'd1)
        / 64'(lirs_pkg::OUT_RATE));

    logic [RW-1:0]                     r_rate;
    logic                              r_stereo;
    logic [STEP_W-1:0]                 r_step;
    logic                              r_step_pend;
    logic [PHASE_W-1:0]                r_phase;
    logic [lirs_pkg::CNT_W-1:0]        r_count;
    logic signed [SW-1:0]              r_prev_l;
    logic signed [SW-1:0]              r_prev_r;
    logic signed [SW-1:0]              r_cur_l;
    logic signed [SW-1:0]              r_cur_r;
    logic signed [PROD_W-1:0]          r_prod_l;
    logic signed [PROD_W-1:0]          r_prod_r;
    logic signed [SW-1:0]              r_out_l;
    logic signed [SW-1:0]              r_out_r;
    logic                              r_out_last;

    logic [RPROD_W-1:0]                w_rprod;
    logic                              w_phase_low;
    logic [PHASE_FRAC_BITS-1:0]        w_frac;
    logic signed [SW:0]                w_diff_l;
    logic signed [SW:0]                w_diff_r;
    logic signed [PROD_W-1:0]          w_prod_l;
    logic signed [PROD_W-1:0]          w_prod_r;
    logic signed [PROD_W-1:0]          w_q_l;
    logic signed [PROD_W-1:0]          w_q_r;
    logic [SW:0]                       w_sum_l;
    logic [SW:0]                       w_sum_r;

    // phase step = (rate << frac) / output rate by reciprocal multiplication
    assign w_rprod = RPROD_W'(r_rate) * RPROD_W'(RECIP);

    assign w_phase_low = (r_phase[PHASE_W-1:PHASE_FRAC_BITS] == 2'b00);
    assign w_frac      = r_phase[PHASE_FRAC_BITS-1:0];

    assign w_diff_l = {r_cur_l[SW-1], r_cur_l} - {r_prev_l[SW-1], r_prev_l};
    assign w_diff_r = {r_cur_r[SW-1], r_cur_r} - {r_prev_r[SW-1], r_prev_r};
    assign w_prod_l = PROD_W'(w_diff_l) * PROD_W'($signed({1'b0, w_frac}));
    assign w_prod_r = PROD_W'(w_diff_r) * PROD_W'($signed({1'b0, w_frac}));

    assign w_q_l   = r_prod_l >>> PHASE_FRAC_BITS;
    assign w_q_r   = r_prod_r >>> PHASE_FRAC_BITS;
    assign w_sum_l = w_q_l[SW:0] + {r_prev_l[SW-1], r_prev_l};
    assign w_sum_r = w_q_r[SW:0] + {r_prev_r[SW-1], r_prev_r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= lirs_pkg::PASS_RATE;
            r_stereo    <= 1'b1;
            r_step      <= STEP_RST;
            r_step_pend <= 1'b0;
            r_phase     <= '0;
            r_count     <= '0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
        end else begin
            if (i_cfg_wr_en && i_cfg_index == lirs_pkg::CFG_SOURCE_RATE) begin
                r_rate      <= i_cfg_wdata;
                r_step_pend <= 1'b1;
            end else if (r_step_pend) begin
                r_step      <= w_rprod[RECIP_SH +: STEP_W];
                r_step_pend <= 1'b0;
            end
            if (i_cfg_wr_en && i_cfg_index == lirs_pkg::CFG_STEREO_INPUT) begin
                r_stereo <= i_cfg_wdata[0];
            end
            if (i_cmd.mul) begin
                r_phase <= r_phase + {1'b0, r_step};
                r_count <= r_count + lirs_pkg::CNT_W'(1);
            end else if (i_cmd.finish) begin
                r_phase  <= w_phase_low ? '0 : r_phase - ONE;
                r_count  <= '0;
                r_prev_l <= r_cur_l;
                r_prev_r <= r_cur_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_l <= i_left;
            r_cur_r <= r_stereo ? i_right : i_left;
        end
        if (i_cmd.mul) begin
            r_prod_l <= w_prod_l;
            r_prod_r <= w_prod_r;
        end
        if (i_cmd.pass) begin
            r_out_l    <= r_cur_l;
            r_out_r    <= r_cur_r;
            r_out_last <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out_l    <= w_sum_l[SW-1:0];
            r_out_r    <= w_sum_r[SW-1:0];
            r_out_last <= !w_phase_low || (r_count == lirs_pkg::CNT_W'(lirs_pkg::MAX_OUT));
        end
    end

    assign o_sts.div_busy  = r_step_pend;
    assign o_sts.pass_mode = (r_rate == lirs_pkg::PASS_RATE);
    assign o_sts.phase_low = w_phase_low;
    assign o_sts.out_last  = r_out_last;

    assign o_left  = r_out_l;
    assign o_right = r_out_r;
    assign o_last  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lirs_pkg::CNT_W'(lirs_pkg::MAX_OUT))
        else $error("output count exceeds frame limit");

    a_mul_phase_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul |-> w_phase_low)
        else $error("interpolation issued with phase at or above one");

    a_finish_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> !r_phase[PHASE_W-1])
        else $error("phase out of range after frame completion");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step_pend |-> !i_cmd.load)
        else $error("frame loaded while phase step is being computed");

endmodule

>>> rtl/lirs_ctrl.sv
// ----------------------------------------------------------------------------
// lirs_ctrl
// Controller: sequences frame load, interpolation, output hold and phase
// update for one input frame at a time.
// ----------------------------------------------------------------------------
module lirs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  lirs_pkg::t_dp_sts   i_sts,
    output lirs_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_EMIT,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !i_sts.div_busy;
                if (i_in_valid && !i_sts.div_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.pass_mode) begin
                    o_cmd.pass  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_HOLD;
                end else if (i_sts.phase_low) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_EMIT;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT: begin
                o_cmd.emit  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_HOLD;
            end
            S_HOLD: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (i_sts.out_last) begin
                        o_cmd.finish = !i_sts.pass_mode;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.mul = 1'b1;
                        n_state   = S_EMIT;
                    end
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_valid_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_HOLD))
        else $error("output valid outside hold state");

    a_pass_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pass |=> i_sts.out_last)
        else $error("passthrough frame not marked last");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && i_sts.out_last) |=> (r_state == S_IDLE))
        else $error("controller kept running after last output");

endmodule
